>>> rtl/core/jac_pkg.sv
// Shared opcodes and constants of the joystick axis calibrator.
`timescale 1ns / 1ps

package jac_pkg;

    // Operation selector carried on the input tuser field.
    typedef logic [2:0] opcode_t;

    localparam opcode_t OP_CONVERT        = 3'd0;
    localparam opcode_t OP_CAPTURE_CENTER = 3'd1;
    localparam opcode_t OP_BEGIN_MIN_MAX  = 3'd2;
    localparam opcode_t OP_CAPTURE_MINMAX = 3'd3;
    localparam opcode_t OP_CENTER_MIDPT   = 3'd4;

    localparam int OPCODE_W = 3;

    // Distance of the starting min/max from center when a sweep begins.
    localparam int SWEEP_OFFSET = 1000;

endpackage

>>> rtl/core/joystick_axis_calibrator.sv
// Joystick axis calibrator top level: calibration state and iterative divider.
`timescale 1ns / 1ps

// Channel  | Direction | tdata fields (lowest bit first)                    | tuser
// ---------+-----------+----------------------------------------------------+--------
// s_ (in)  | input     | sample                                             | opcode
// m_ (out) | output    | calibrated, center_now, minimum_now, maximum_now   | none
//
// One item is handled at a time and s_tready is high only while the block is idle.
// A convert that divides works through offset and span, one compare and one restoring step
// per fraction bit on the shared subtractor, then the output register. A convert that ends
// at zero or full scale skips the division steps; other opcodes update the calibration state
// and go to the output register. The next transfer is taken while a result waits for m_tready;
// it then holds before the output register. aresetn clears center, minimum, maximum and m_tvalid.

module joystick_axis_calibrator #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 15
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: sample [SAMPLE_BITS-1:0], zero padded to whole bytes.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: opcode [2:0].
    input  logic [jac_pkg::OPCODE_W-1:0]           s_tuser,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: calibrated, center_now, minimum_now, maximum_now, zero padded to bytes.
    output logic [((FRAC_BITS + 2 + 3 * (SAMPLE_BITS + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int STATE_W = SAMPLE_BITS + 1;
    localparam int DIFF_W  = SAMPLE_BITS + 2;
    localparam int TRIAL_W = DIFF_W + 1;
    localparam int OUT_W   = FRAC_BITS + 2;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int CNT_W   = $clog2(FRAC_BITS + 1);
    localparam int PAY_W   = OUT_W + 3 * STATE_W;
    localparam int M_W     = ((PAY_W + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                     state_reg, state_next;
    jac_pkg::opcode_t               op_reg, op_next;
    logic [SAMPLE_BITS-1:0]         sample_reg, sample_next;
    logic [STATE_W-1:0]             center_reg, center_next;
    logic [STATE_W-1:0]             min_reg, min_next;
    logic [STATE_W-1:0]             max_reg, max_next;
    logic [DIFF_W-1:0]              n_reg, n_next;
    logic [DIFF_W-1:0]              d_reg, d_next;
    logic [DIFF_W-1:0]              r_reg, r_next;
    logic [Q_W-1:0]                 q_reg, q_next;
    logic                           neg_reg, neg_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [M_W-1:0]                 m_tdata_reg, m_tdata_next;

    logic [STATE_W-1:0]             sample_st;
    logic [DIFF_W-1:0]              sample_d, center_d, min_d, max_d;
    logic [DIFF_W-1:0]              num_d, den_hi, den_lo, den_d;
    logic [DIFF_W-1:0]              mid_sum, mid_adj;
    logic [TRIAL_W-1:0]             trial_a;
    logic [TRIAL_W:0]               trial_diff;
    logic                           trial_ge;
    logic [OUT_W-1:0]               cal_mag, cal_value;
    logic                           out_free;

    // Sign-extended views of the sample and the stored state.
    assign sample_st = {{(STATE_W - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign sample_d  = {{(DIFF_W - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign center_d  = {center_reg[STATE_W-1], center_reg};
    assign min_d     = {min_reg[STATE_W-1], min_reg};
    assign max_d     = {max_reg[STATE_W-1], max_reg};

    assign num_d  = sample_d - center_d;
    assign den_hi = max_d - center_d;
    assign den_lo = center_d - min_d;

    // Pick the span on the sample's side; a sample at center or a zero span gives 0.
    always_comb begin
        den_d = '0;
        if ($signed(center_d) < $signed(sample_d) && max_reg != center_reg) begin
            den_d = den_hi;
        end else if ($signed(sample_d) < $signed(center_d) && min_reg != center_reg) begin
            den_d = den_lo;
        end
    end

    // Midpoint truncated toward zero: add one before the shift when the sum is negative.
    assign mid_sum = min_d + max_d;
    assign mid_adj = mid_sum + DIFF_W'(mid_sum[DIFF_W-1]);

    // The one subtractor that serves both the clamp compare and every division step.
    assign trial_a    = (state_reg == ST_CMP) ? {1'b0, n_reg} : {r_reg, 1'b0};
    assign trial_diff = {1'b0, trial_a} - {2'b00, d_reg};
    assign trial_ge   = ~trial_diff[TRIAL_W];

    assign cal_mag   = {1'b0, q_reg};
    assign cal_value = neg_reg ? (~cal_mag + OUT_W'(1)) : cal_mag;
    assign out_free  = ~m_tvalid_reg | m_tready;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        sample_next   = sample_reg;
        center_next   = center_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    sample_next = s_tdata[SAMPLE_BITS-1:0];
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                q_next     = '0;
                neg_next   = 1'b0;
                state_next = ST_OUT;
                case (op_reg)
                    jac_pkg::OP_CONVERT: begin
                        n_next     = num_d[DIFF_W-1] ? (~num_d + DIFF_W'(1)) : num_d;
                        d_next     = den_d[DIFF_W-1] ? (~den_d + DIFF_W'(1)) : den_d;
                        neg_next   = num_d[DIFF_W-1] ^ den_d[DIFF_W-1];
                        state_next = ST_CMP;
                    end
                    jac_pkg::OP_CAPTURE_CENTER: begin
                        center_next = sample_st;
                    end
                    jac_pkg::OP_BEGIN_MIN_MAX: begin
                        min_next = center_reg + STATE_W'(jac_pkg::SWEEP_OFFSET);
                        max_next = center_reg - STATE_W'(jac_pkg::SWEEP_OFFSET);
                    end
                    jac_pkg::OP_CAPTURE_MINMAX: begin
                        if ($signed(sample_st) < $signed(min_reg)) begin
                            min_next = sample_st;
                        end
                        if ($signed(sample_st) > $signed(max_reg)) begin
                            max_next = sample_st;
                        end
                    end
                    jac_pkg::OP_CENTER_MIDPT: begin
                        center_next = mid_adj[STATE_W:1];
                    end
                    default: begin
                    end
                endcase
            end
            ST_CMP: begin
                if (n_reg == '0 || d_reg == '0) begin
                    q_next     = '0;
                    state_next = ST_OUT;
                end else if (trial_ge) begin
                    // Offset reaches the span: exactly full scale.
                    q_next     = Q_W'(1) << FRAC_BITS;
                    state_next = ST_OUT;
                end else begin
                    r_next     = n_reg;
                    cnt_next   = CNT_W'(FRAC_BITS);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (trial_ge) begin
                    r_next = trial_diff[DIFF_W-1:0];
                    q_next = {q_reg[Q_W-2:0], 1'b1};
                end else begin
                    r_next = {r_reg[DIFF_W-2:0], 1'b0};
                    q_next = {q_reg[Q_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_W'({max_reg, min_reg, center_reg, cal_value});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            center_reg   <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            center_reg   <= center_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        sample_reg  <= sample_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        r_reg       <= r_next;
        q_reg       <= q_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The division never runs with an exhausted step counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("division step with zero count");

    // An accepted item always starts its work in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted item did not start");

    // A calibrated value never exceeds full scale in either direction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (q_reg <= (Q_W'(1) << FRAC_BITS)))
        else $error("calibrated magnitude above one");

    // Only a convert produces a nonzero calibrated value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && op_reg != jac_pkg::OP_CONVERT) |-> (q_reg == '0))
        else $error("nonzero calibrated value for a state operation");

endmodule
